@@ sv/uvs_pkg.sv @@
// ----------------------------------------------------------------------------
// UV sphere vertex generator package
// Shared widths, register indexes, arctangent table and rounding helpers.
// ----------------------------------------------------------------------------
package uvs_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int DIV_STEPS     = 16;
    localparam int IDX_W         = $clog2(ATAN_ENTRIES);
    localparam int CW            = 34;   // Q2.30 datapath width with headroom

    localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_RADIUS = 2'd0,
        REG_COLS   = 2'd1,
        REG_RINGS  = 2'd2,
        REG_NONE   = 2'd3
    } cfg_reg_t;

    // arctangent of 2^-i, 2^32 per full turn
    localparam logic signed [CW-1:0] ATAN_TURN32 [ATAN_ENTRIES] = '{
        34'sh020000000, 34'sh012E4051E, 34'sh009FB385B, 34'sh0051111D4,
        34'sh0028B0D43, 34'sh00145D7E1, 34'sh000A2F61E, 34'sh000517C55,
        34'sh00028BE53, 34'sh000145F2F, 34'sh0000A2F98, 34'sh0000517CC,
        34'sh000028BE6, 34'sh0000145F3, 34'sh00000A2FA, 34'sh00000517D,
        34'sh0000028BE, 34'sh00000145F, 34'sh000000A30, 34'sh000000518,
        34'sh00000028C, 34'sh000000146, 34'sh0000000A3, 34'sh000000051
    };

    // per-point data that rides alongside the arithmetic chains
    typedef struct packed {
        logic [15:0] quad_base;
        logic        quad_valid;
        logic [16:0] tex_u;
        logic [16:0] tex_v;
    } side_t;

    // Q2.30 to Q1.15, round half up, saturate
    function automatic logic signed [15:0] q30_to_q15(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] t;
        t = (v + 34'sd16384) >>> 15;
        if (t > 34'sd32767) begin
            return 16'sh7FFF;
        end else if (t < -34'sd32768) begin
            return 16'sh8000;
        end
        return t[15:0];
    endfunction

    // Q2.30 product of two Q1.15 values back to Q1.15, round half up, saturate
    function automatic logic signed [15:0] prod_to_q15(input logic signed [31:0] p);
        logic signed [CW-1:0] t;
        t = (CW'(p) + 34'sd16384) >>> 15;
        if (t > 34'sd32767) begin
            return 16'sh7FFF;
        end else if (t < -34'sd32768) begin
            return 16'sh8000;
        end
        return t[15:0];
    endfunction

endpackage

@@ sv/uvs_div_cell.sv @@
// ----------------------------------------------------------------------------
// Divider cell
// One restoring step of the texture coordinate division: shifts in a zero
// bit, subtracts the divisor when it fits and registers the result.
// ----------------------------------------------------------------------------
module uvs_div_cell (
    input  logic        aclk,
    input  logic        en,
    input  logic [7:0]  rem_i,
    input  logic [16:0] quo_i,
    input  logic [7:0]  dvs_i,
    output logic [7:0]  rem_o,
    output logic [16:0] quo_o,
    output logic [7:0]  dvs_o
);

    logic [8:0]  trial;
    logic [8:0]  diff;
    logic        fits;
    logic [7:0]  rem_next;
    logic [16:0] quo_next;
    logic [7:0]  rem_reg;
    logic [16:0] quo_reg;
    logic [7:0]  dvs_reg;

    always_comb begin
        trial    = {rem_i, 1'b0};
        diff     = trial - {1'b0, dvs_i};
        fits     = (trial >= {1'b0, dvs_i});
        rem_next = fits ? diff[7:0] : trial[7:0];
        quo_next = {quo_i[15:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            dvs_reg <= dvs_i;
        end
    end

    assign rem_o = rem_reg;
    assign quo_o = quo_reg;
    assign dvs_o = dvs_reg;

endmodule

@@ sv/uvs_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// CORDIC cell
// One rotation-mode micro-rotation; the stage number selects shift and angle.
// ----------------------------------------------------------------------------
module uvs_cordic_cell (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [uvs_pkg::IDX_W-1:0]      stage_i,
    input  logic signed [uvs_pkg::CW-1:0]  x_i,
    input  logic signed [uvs_pkg::CW-1:0]  y_i,
    input  logic signed [uvs_pkg::CW-1:0]  z_i,
    input  logic [1:0]                     quad_i,
    output logic signed [uvs_pkg::CW-1:0]  x_o,
    output logic signed [uvs_pkg::CW-1:0]  y_o,
    output logic signed [uvs_pkg::CW-1:0]  z_o,
    output logic [1:0]                     quad_o
);

    logic signed [uvs_pkg::CW-1:0] dx;
    logic signed [uvs_pkg::CW-1:0] dy;
    logic signed [uvs_pkg::CW-1:0] ang;
    logic signed [uvs_pkg::CW-1:0] x_next;
    logic signed [uvs_pkg::CW-1:0] y_next;
    logic signed [uvs_pkg::CW-1:0] z_next;
    logic signed [uvs_pkg::CW-1:0] x_reg;
    logic signed [uvs_pkg::CW-1:0] y_reg;
    logic signed [uvs_pkg::CW-1:0] z_reg;
    logic [1:0]                    quad_reg;

    always_comb begin
        dx  = y_i >>> stage_i;
        dy  = x_i >>> stage_i;
        ang = uvs_pkg::ATAN_TURN32[stage_i];
        // rotate toward zero residual angle
        if (!z_i[uvs_pkg::CW-1]) begin
            x_next = x_i - dx;
            y_next = y_i + dy;
            z_next = z_i - ang;
        end else begin
            x_next = x_i + dx;
            y_next = y_i - dy;
            z_next = z_i + ang;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            quad_reg <= quad_i;
        end
    end

    assign x_o    = x_reg;
    assign y_o    = y_reg;
    assign z_o    = z_reg;
    assign quad_o = quad_reg;

endmodule

@@ sv/uv_sphere_vertex_generator_top.sv @@
// ----------------------------------------------------------------------------
// UV sphere vertex generator
// Turns a (column, row) grid point into position, normal, texture
// coordinates, tangent and quad index of a latitude-longitude sphere.
// ----------------------------------------------------------------------------
// One vertex request is taken per clock when not stalled and each gives
// exactly one result. The pipeline has one input stage, 16 divider cells for
// the texture coordinates, one angle-reduction stage, one CORDIC cell per
// stage for each of the two angles, then rounding, normal product and
// position product stages. The pipeline stalls as a whole only while the
// output register holds a result that is not taken. Write configuration only
// while no request is in flight.
module uv_sphere_vertex_generator_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // grid_col, grid_row
    output logic         m_tvalid,
    input  logic         m_tready,
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v, tang_x,
    // tang_z, quad_base, zero fill
    output logic [183:0] m_tdata,
    output logic [0:0]   m_tuser    // quad_valid
);

    localparam int CS    = uvs_pkg::CORDIC_STAGES;
    localparam int DS    = uvs_pkg::DIV_STEPS;
    localparam int CW    = uvs_pkg::CW;
    localparam int PRE   = DS + 1;
    localparam int POST  = PRE + CS + 1;
    localparam int MUL   = POST + 1;
    localparam int OUTS  = MUL + 1;
    localparam int NST   = OUTS + 1;

    // configuration
    logic [15:0] radius_reg;
    logic [7:0]  cols_reg;
    logic [7:0]  rings_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= 16'd256;
            cols_reg   <= 8'd16;
            rings_reg  <= 8'd16;
        end else if (cfg_we) begin
            case (uvs_pkg::cfg_reg_t'(cfg_index))
                uvs_pkg::REG_RADIUS: radius_reg <= cfg_wdata;
                uvs_pkg::REG_COLS:   cols_reg   <= cfg_wdata[7:0];
                uvs_pkg::REG_RINGS:  rings_reg  <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // stage control
    logic           en;
    logic [NST-1:0] vld_reg;

    assign en       = !vld_reg[NST-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
        end
    end

    // input stage: clamp, divider seed, vertex index
    logic [7:0]  cc;
    logic [7:0]  rc;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [15:0] qb_wide;
    uvs_pkg::side_t side_in;

    always_comb begin
        cc  = (cols_reg  == 8'd0) ? 8'd1 : cols_reg;
        rc  = (rings_reg == 8'd0) ? 8'd1 : rings_reg;
        col = (s_tdata[7:0]  > cc) ? cc : s_tdata[7:0];
        row = (s_tdata[15:8] > rc) ? rc : s_tdata[15:8];
        qb_wide = 16'(row) * 16'({1'b0, cc} + 9'd1) + 16'(col);
        side_in.quad_base  = qb_wide;
        side_in.quad_valid = (col < cc) && (row < rc);
        side_in.tex_u      = '0;
        side_in.tex_v      = '0;
    end

    logic [7:0]  ur [0:DS];
    logic [16:0] uq [0:DS];
    logic [7:0]  ud [0:DS];
    logic [7:0]  vr [0:DS];
    logic [16:0] vq [0:DS];
    logic [7:0]  vd [0:DS];

    always_ff @(posedge aclk) begin
        if (en) begin
            // col never exceeds cc, so the top quotient bit is col == cc
            ur[0] <= (col == cc) ? 8'd0 : col;
            uq[0] <= {16'd0, col == cc};
            ud[0] <= cc;
            vr[0] <= (row == rc) ? 8'd0 : row;
            vq[0] <= {16'd0, row == rc};
            vd[0] <= rc;
        end
    end

    for (genvar c = 0; c < DS; c++) begin : g_div
        uvs_div_cell u_div_u (
            .aclk (aclk), .en (en),
            .rem_i (ur[c]), .quo_i (uq[c]), .dvs_i (ud[c]),
            .rem_o (ur[c+1]), .quo_o (uq[c+1]), .dvs_o (ud[c+1])
        );
        uvs_div_cell u_div_v (
            .aclk (aclk), .en (en),
            .rem_i (vr[c]), .quo_i (vq[c]), .dvs_i (vd[c]),
            .rem_o (vr[c+1]), .quo_o (vq[c+1]), .dvs_o (vd[c+1])
        );
    end

    // side data, texture coordinates joined at the end of the divider
    uvs_pkg::side_t side_reg  [0:NST-1];
    uvs_pkg::side_t side_next [0:NST-1];

    always_comb begin
        side_next[0] = side_in;
        for (int k = 1; k < NST; k++) begin
            side_next[k] = side_reg[k-1];
        end
        side_next[PRE].tex_u = uq[DS];
        side_next[PRE].tex_v = vq[DS];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg <= side_next;
        end
    end

    // angle reduction to nearest quarter turn
    logic [16:0] ph_t;
    logic [16:0] ph_p;
    logic [17:0] sum_t;
    logic [17:0] sum_p;

    always_comb begin
        ph_t  = {uq[DS][15:0], 1'b0};
        ph_p  = vq[DS];
        sum_t = {1'b0, ph_t} + 18'd16384;
        sum_p = {1'b0, ph_p} + 18'd16384;
    end

    logic signed [CW-1:0] tx [0:CS];
    logic signed [CW-1:0] ty [0:CS];
    logic signed [CW-1:0] tz [0:CS];
    logic [1:0]           tq [0:CS];
    logic signed [CW-1:0] px [0:CS];
    logic signed [CW-1:0] py [0:CS];
    logic signed [CW-1:0] pz [0:CS];
    logic [1:0]           pq [0:CS];

    always_ff @(posedge aclk) begin
        if (en) begin
            tx[0] <= uvs_pkg::CORDIC_GAIN_Q30;
            ty[0] <= '0;
            tz[0] <= (CW'(signed'({1'b0, sum_t[14:0]})) - CW'(16384)) <<< 15;
            tq[0] <= sum_t[16:15];
            px[0] <= uvs_pkg::CORDIC_GAIN_Q30;
            py[0] <= '0;
            pz[0] <= (CW'(signed'({1'b0, sum_p[14:0]})) - CW'(16384)) <<< 15;
            pq[0] <= sum_p[16:15];
        end
    end

    for (genvar k = 0; k < CS; k++) begin : g_cordic
        uvs_cordic_cell u_cor_t (
            .aclk (aclk), .en (en), .stage_i (uvs_pkg::IDX_W'(k)),
            .x_i (tx[k]), .y_i (ty[k]), .z_i (tz[k]), .quad_i (tq[k]),
            .x_o (tx[k+1]), .y_o (ty[k+1]), .z_o (tz[k+1]), .quad_o (tq[k+1])
        );
        uvs_cordic_cell u_cor_p (
            .aclk (aclk), .en (en), .stage_i (uvs_pkg::IDX_W'(k)),
            .x_i (px[k]), .y_i (py[k]), .z_i (pz[k]), .quad_i (pq[k]),
            .x_o (px[k+1]), .y_o (py[k+1]), .z_o (pz[k+1]), .quad_o (pq[k+1])
        );
    end

    // quadrant unfold and rounding
    logic signed [CW-1:0] c_t, s_t, c_p, s_p;

    always_comb begin
        case (tq[CS])
            2'd0:    begin c_t = tx[CS];  s_t = ty[CS];  end
            2'd1:    begin c_t = -ty[CS]; s_t = tx[CS];  end
            2'd2:    begin c_t = -tx[CS]; s_t = -ty[CS]; end
            default: begin c_t = ty[CS];  s_t = -tx[CS]; end
        endcase
        case (pq[CS])
            2'd0:    begin c_p = px[CS];  s_p = py[CS];  end
            2'd1:    begin c_p = -py[CS]; s_p = px[CS];  end
            2'd2:    begin c_p = -px[CS]; s_p = -py[CS]; end
            default: begin c_p = py[CS];  s_p = -px[CS]; end
        endcase
    end

    logic signed [15:0] ct_reg, st_reg, cp_reg, sp_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ct_reg <= uvs_pkg::q30_to_q15(c_t);
            st_reg <= uvs_pkg::q30_to_q15(s_t);
            cp_reg <= uvs_pkg::q30_to_q15(c_p);
            sp_reg <= uvs_pkg::q30_to_q15(s_p);
        end
    end

    // normal and tangent
    logic signed [15:0] nx_reg, ny_reg, nz_reg, tgx_reg, tgz_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            nx_reg  <= uvs_pkg::prod_to_q15(sp_reg * ct_reg);
            ny_reg  <= cp_reg;
            nz_reg  <= uvs_pkg::prod_to_q15(sp_reg * st_reg);
            tgx_reg <= (st_reg == 16'sh8000) ? 16'sh7FFF : -st_reg;
            tgz_reg <= ct_reg;
        end
    end

    // position and output register
    logic signed [16:0] rad_s;
    logic signed [CW-1:0] mx, my, mz;

    always_comb begin
        rad_s = signed'({1'b0, radius_reg});
        mx = (CW'(rad_s) * CW'(nx_reg) + CW'(16384)) >>> 15;
        my = (CW'(rad_s) * CW'(ny_reg) + CW'(16384)) >>> 15;
        mz = (CW'(rad_s) * CW'(nz_reg) + CW'(16384)) >>> 15;
    end

    logic [16:0] posx_reg, posy_reg, posz_reg;
    logic [15:0] onx_reg, ony_reg, onz_reg, otx_reg, otz_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            posx_reg <= mx[16:0];
            posy_reg <= my[16:0];
            posz_reg <= mz[16:0];
            onx_reg  <= nx_reg;
            ony_reg  <= ny_reg;
            onz_reg  <= nz_reg;
            otx_reg  <= tgx_reg;
            otz_reg  <= tgz_reg;
        end
    end

    assign m_tdata = {3'd0, side_reg[OUTS].quad_base, otz_reg, otx_reg,
                      side_reg[OUTS].tex_v, side_reg[OUTS].tex_u,
                      onz_reg, ony_reg, onx_reg, posz_reg, posy_reg, posx_reg};
    assign m_tuser = side_reg[OUTS].quad_valid;

`ifndef SYNTHESIS
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted request did not enter the pipeline");
    a_quad_tex: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (!m_tdata[115] && !m_tdata[132]))
        else $error("quad start with texture coordinate of one");
    a_tex_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[115:99] <= 17'd65536 && m_tdata[132:116] <= 17'd65536))
        else $error("texture coordinate above one");
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");
`endif

endmodule

@@ tb/sv/tb_uv_sphere_vertex_generator_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UV sphere vertex generator testbench
// Streams grid points through the block under several radius and count
// settings, predicts every vertex with an independent CORDIC model and
// compares each result field by field, with random idling on both sides.
// ----------------------------------------------------------------------------

class vertex_scoreboard;
    typedef struct {
        logic [183:0] data;
        logic         quad;
    } vertex_t;

    vertex_t     pending_q[$];
    int          mismatches;
    logic [15:0] radius;
    logic [7:0]  cols;
    logic [7:0]  rings;

    function new();
        mismatches = 0;
        radius = 16'd256;
        cols = 8'd16;
        rings = 8'd16;
    endfunction

    static function longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    static function longint clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    static function longint atan_step(int i);
        longint tbl[24] = '{
            64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
            64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
            64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
            64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
            64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
            64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};
        return tbl[i];
    endfunction

    // phase of 2^17 per turn -> Q1.15 cosine and sine
    static function void rotate_phase(logic [16:0] ph, output longint c, output longint s);
        longint x, y, z, dx, dy, rc, rs;
        int quadrant;
        quadrant = ((ph + 17'd16384) >> 15) & 3;
        z = (longint'((ph + 32'd16384) & 32'h7FFF) - 16384) * 32768;
        x = 652032874;
        y = 0;
        for (int i = 0; i < uvs_pkg::CORDIC_STAGES && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_step(i);
            end else begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        case (quadrant)
            0: begin rc = x; rs = y; end
            1: begin rc = -y; rs = x; end
            2: begin rc = -x; rs = -y; end
            default: begin rc = y; rs = -x; end
        endcase
        c = clip16((rc + 16384) >>> 15);
        s = clip16((rs + 16384) >>> 15);
    endfunction

    function longint scale(longint n);
        return (longint'(radius) * n + 16384) >>> 15;
    endfunction

    function void write_reg(uvs_pkg::cfg_reg_t idx, logic [15:0] val);
        case (idx)
            uvs_pkg::REG_RADIUS: radius = val;
            uvs_pkg::REG_COLS: cols = val[7:0];
            uvs_pkg::REG_RINGS: rings = val[7:0];
            default: ;
        endcase
    endfunction

    function void note_point(logic [7:0] col_in, logic [7:0] row_in);
        longint cc, rc, col, row, u, v, ct, st, cp, sp, nx, ny, nz;
        vertex_t e;
        cc = (cols == 0) ? 1 : cols;
        rc = (rings == 0) ? 1 : rings;
        col = (col_in > cc) ? cc : col_in;
        row = (row_in > rc) ? rc : row_in;
        u = (col << 16) / cc;
        v = (row << 16) / rc;
        rotate_phase(17'(u << 1), ct, st);
        rotate_phase(17'(v), cp, sp);
        nx = clip16((sp * ct + 16384) >>> 15);
        ny = cp;
        nz = clip16((sp * st + 16384) >>> 15);
        e.data = '0;
        e.data[16:0] = 17'(scale(nx));
        e.data[33:17] = 17'(scale(ny));
        e.data[50:34] = 17'(scale(nz));
        e.data[66:51] = 16'(nx);
        e.data[82:67] = 16'(ny);
        e.data[98:83] = 16'(nz);
        e.data[115:99] = 17'(u);
        e.data[132:116] = 17'(v);
        e.data[148:133] = 16'(clip16(-st));
        e.data[164:149] = 16'(ct);
        e.data[180:165] = 16'(row * (cc + 1) + col);
        e.quad = (col < cc && row < rc);
        pending_q = {pending_q, e};
    endfunction

    task report(string what, logic [183:0] got, logic [183:0] exp);
        mismatches++;
        $display("MISMATCH %s: got %h expected %h", what, got, exp);
    endtask

    task check_vertex(logic [183:0] data, logic quad);
        vertex_t e;
        if (pending_q.size() == 0) begin
            report("unexpected result", data, '0);
            return;
        end
        e = pending_q.pop_front();
        if (data[16:0] !== e.data[16:0]) report("pos_x", data[16:0], e.data[16:0]);
        if (data[33:17] !== e.data[33:17]) report("pos_y", data[33:17], e.data[33:17]);
        if (data[50:34] !== e.data[50:34]) report("pos_z", data[50:34], e.data[50:34]);
        if (data[66:51] !== e.data[66:51]) report("norm_x", data[66:51], e.data[66:51]);
        if (data[82:67] !== e.data[82:67]) report("norm_y", data[82:67], e.data[82:67]);
        if (data[98:83] !== e.data[98:83]) report("norm_z", data[98:83], e.data[98:83]);
        if (data[115:99] !== e.data[115:99]) report("tex_u", data[115:99], e.data[115:99]);
        if (data[132:116] !== e.data[132:116])
            report("tex_v", data[132:116], e.data[132:116]);
        if (data[148:133] !== e.data[148:133])
            report("tang_x", data[148:133], e.data[148:133]);
        if (data[164:149] !== e.data[164:149])
            report("tang_z", data[164:149], e.data[164:149]);
        if (data[180:165] !== e.data[180:165])
            report("quad_base", data[180:165], e.data[180:165]);
        if (data[183:181] !== 3'b0) report("fill", data[183:181], '0);
        if (quad !== e.quad) report("quad_valid", quad, e.quad);
    endtask
endclass

module tb_uv_sphere_vertex_generator_top;

    localparam int LATENCY = uvs_pkg::CORDIC_STAGES + 21;
    localparam int STALL_LIMIT = 5000;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [15:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [15:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [183:0] m_tdata;
    logic [0:0]   m_tuser;

    vertex_scoreboard sb;
    bit  calm_mode;
    bit  hold_sink;
    int  idle_cycles;

    uv_sphere_vertex_generator_top u_dut (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic bit take_gap();
        return !calm_mode && ($urandom_range(99) < 26);
    endfunction

    // one write, then the enable driven low again before the task returns
    task automatic write_cfg(uvs_pkg::cfg_reg_t idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        sb.write_reg(idx, val);
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // offer one grid point, hold until taken
    task automatic send_point(logic [7:0] col, logic [7:0] row);
        while (take_gap()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {row, col};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_point(col, row);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic random_points(int n);
        logic [7:0] c, r;
        for (int i = 0; i < n; i++) begin
            // mostly in-range points, some past the counts
            if ($urandom_range(3) == 0) begin
                c = 8'($urandom_range(255));
                r = 8'($urandom_range(255));
            end else begin
                c = 8'($urandom_range(sb.cols));
                r = 8'($urandom_range(sb.rings));
            end
            send_point(c, r);
        end
    endtask

    // sink with random stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) sb.check_vertex(m_tdata, m_tuser[0]);
            m_tready <= !hold_sink && !take_gap();
        end
    end

    // watchdog on handshake activity
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        sb = new();
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = uvs_pkg::REG_RADIUS;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        calm_mode = 1'b0;
        hold_sink = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset settings, corners, poles, seam, clamping
        send_point(8'd0, 8'd0);
        send_point(8'd16, 8'd16);
        send_point(8'd15, 8'd15);
        send_point(8'd4, 8'd8);
        send_point(8'd8, 8'd4);
        send_point(8'd12, 8'd12);
        send_point(8'd255, 8'd255);
        send_point(8'd170, 8'd85);
        send_point(8'd85, 8'd170);
        drain();
        write_cfg(uvs_pkg::REG_RADIUS, 16'hFFFF);
        write_cfg(uvs_pkg::REG_COLS, 16'd0);
        write_cfg(uvs_pkg::REG_RINGS, 16'd0);
        write_cfg(uvs_pkg::REG_NONE, 16'h1234);
        send_point(8'd0, 8'd0);
        send_point(8'd1, 8'd1);
        send_point(8'd200, 8'd0);
        drain();
        write_cfg(uvs_pkg::REG_RADIUS, 16'd0);
        write_cfg(uvs_pkg::REG_COLS, 16'd255);
        write_cfg(uvs_pkg::REG_RINGS, 16'd255);
        send_point(8'd0, 8'd127);
        send_point(8'd254, 8'd254);
        send_point(8'd255, 8'd255);
        send_point(8'd64, 8'd191);
        drain();

        // random phases over several settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_cfg(uvs_pkg::REG_RADIUS, 16'hFFFF);
                    write_cfg(uvs_pkg::REG_COLS, 16'd255);
                    write_cfg(uvs_pkg::REG_RINGS, 16'd1);
                end
                1: begin
                    write_cfg(uvs_pkg::REG_COLS, 16'd1);
                    write_cfg(uvs_pkg::REG_RINGS, 16'd255);
                end
                default: begin
                    write_cfg(uvs_pkg::REG_RADIUS, 16'($urandom_range(65535)));
                    write_cfg(uvs_pkg::REG_COLS, 16'($urandom_range(255)));
                    write_cfg(uvs_pkg::REG_RINGS, 16'($urandom_range(255)));
                end
            endcase
            if (ph == 2) begin
                // back-pressure: freeze the sink while the source keeps offering
                fork
                    begin
                        hold_sink <= 1'b1;
                        repeat (200) @(posedge aclk);
                        hold_sink <= 1'b0;
                    end
                    random_points(70);
                join
            end else if (ph == 3) begin
                calm_mode = 1'b1;
                random_points(70);
                calm_mode = 1'b0;
            end else begin
                random_points(70);
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
